>>> rtl/ofc_pkg.sv
// Shared types and constants for the overlay alpha/fade compositor.
// Used by all modules under rtl/.
package ofc_pkg;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] pix_red;
        logic [7:0] pix_green;
        logic [7:0] pix_blue;
    } ofc_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       frame_end;
    } ofc_out_t;

    typedef enum logic [1:0] {
        ST_SETUP,
        ST_DIV,
        ST_RUN
    } ofc_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic clear_pos;
        logic out_load;
        logic div_load;
        logic div_step;
    } ofc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic row_end;
        logic restart;
        logic fade_trivial;
        logic div_last;
    } ofc_sts_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_ZERO      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_OPAQUE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_OPAQUE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_ZERO   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PLATE_ENABLE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PLATE_COLOR   = 3'd7;

    localparam logic [7:0] ALPHA_FLOOR = 8'd150;
    localparam logic [7:0] ALPHA_FULL  = 8'd255;

endpackage

>>> rtl/ofc_fade.sv
// Row fade unit: band selection and iterative restoring divider, one quotient
// bit per cycle. Depends on ofc_pkg.
module ofc_fade #(
    parameter int F  = 8,
    parameter int RW = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ofc_pkg::ofc_cmd_t cmd,
    input  logic [RW-1:0]    row,
    input  logic [13:0]      top_zero,
    input  logic [13:0]      top_opaque,
    input  logic [13:0]      bottom_opaque,
    input  logic [13:0]      bottom_zero,
    output logic [F:0]       fade,
    output logic             trivial,
    output logic             div_last
);
    import ofc_pkg::*;

    localparam int PW   = ((RW + 1) > 14) ? RW + 1 : 14;
    localparam int NW   = PW + F + 1;
    localparam int CNTW = $clog2(F + 1);
    localparam logic [F:0] FADE_ONE = {1'b1, {F{1'b0}}};

    logic [PW-1:0]   p, tz, tq, bq, bz, num, den;
    logic [F:0]      triv_val;
    logic [NW-1:0]   dvd;
    logic [PW:0]     trial;
    logic            ge;
    logic [PW-1:0]   rem_n;
    logic [F:0]      q_n;

    logic [PW-1:0]   rem_reg, den_reg;
    logic [F:0]      qsh_reg, fade_reg;
    logic [CNTW-1:0] cnt_reg;

    always_comb begin
        p  = PW'({row, 1'b0});
        tz = PW'(top_zero);
        tq = PW'(top_opaque);
        bq = PW'(bottom_opaque);
        bz = PW'(bottom_zero);
        num      = '0;
        den      = '0;
        trivial  = 1'b1;
        triv_val = '0;
        if (p < tq) begin
            if (p > tz) begin
                trivial = 1'b0;
                num     = p - tz;
                den     = tq - tz;
            end
        end else if (p > bq) begin
            if (p < bz) begin
                trivial = 1'b0;
                num     = bz - p;
                den     = bz - bq;
            end
        end else begin
            triv_val = FADE_ONE;
        end
        // rounded: (num << F) + den/2; num < den keeps the quotient within F+1 bits
        dvd = (NW'(num) << F) + NW'(den >> 1);
    end

    always_comb begin
        trial = {rem_reg, qsh_reg[F]};
        ge    = trial >= {1'b0, den_reg};
        rem_n = ge ? PW'(trial - {1'b0, den_reg}) : trial[PW-1:0];
        q_n   = {qsh_reg[F-1:0], ge};
    end

    assign div_last = (cnt_reg == '0);
    assign fade     = fade_reg;

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            rem_reg <= dvd[NW-1:F+1];
            qsh_reg <= dvd[F:0];
            den_reg <= den;
        end else if (cmd.div_step) begin
            rem_reg <= rem_n;
            qsh_reg <= q_n;
        end
        if (cmd.div_load && trivial) begin
            fade_reg <= triv_val;
        end else if (cmd.div_step && div_last) begin
            fade_reg <= q_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_load) begin
            cnt_reg <= CNTW'(F);
        end else if (cmd.div_step && !div_last) begin
            cnt_reg <= cnt_reg - CNTW'(1);
        end
    end

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

    a_fade_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && div_last) |-> q_n <= FADE_ONE)
        else $error("fade quotient above one");

endmodule

>>> rtl/ofc_pixel.sv
// Pixel datapath: raster counters, alpha derivation, fade scaling and plate
// blend in two register stages. Depends on ofc_pkg.
module ofc_pixel #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int F          = 8,
    parameter int CW         = 12,
    parameter int RW         = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ofc_pkg::ofc_cmd_t cmd,
    input  ofc_pkg::ofc_in_t  s_data,
    input  logic [F:0]        fade,
    input  logic [12:0]       frame_width,
    input  logic [12:0]       frame_height,
    input  logic              plate_enable,
    input  logic [23:0]       plate_color,
    output ofc_pkg::ofc_out_t m_data,
    output logic [RW-1:0]     row,
    output logic              row_end,
    output logic              restart
);
    import ofc_pkg::*;

    localparam int SW = ((CW > 13) ? CW : 13) + 1;
    localparam int SH = ((RW > 13) ? RW : 13) + 1;
    localparam int AW = F + 9;
    localparam logic [AW:0] HALF = (AW + 1)'(1) << (F - 1);

    logic [CW-1:0] col_reg, col_eff;
    logic [RW-1:0] row_reg;
    logic [SW-1:0] fw, w_eff;
    logic [SH-1:0] fh, h_eff;
    logic          last_row;

    logic [7:0]    mx, alpha, alpha_inv, alpha_mul;
    logic [7:0]    plate_r, plate_g, plate_b;

    logic [7:0]    st1_r_reg, st1_g_reg, st1_b_reg;
    logic [15:0]   st1_mr_reg, st1_mg_reg, st1_mb_reg;
    logic [15:0]   st1_pr_reg, st1_pg_reg, st1_pb_reg;
    logic [AW-1:0] st1_am_reg;
    logic          st1_end_reg;
    logic          st1_plate_reg;
    ofc_out_t      out_reg, out_next;
    logic [AW:0]   alpha_rnd;

    // floor(x / 255) for x = a + b + 127 below 65535
    function automatic logic [7:0] div255(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s, q;
        s = 17'(a) + 17'(b) + 17'd127;
        q = (s + 17'd1 + (s >> 8)) >> 8;
        return q[7:0];
    endfunction

    // effective frame size, clamped to 1 .. MAX
    always_comb begin
        fw = SW'(frame_width);
        fh = SH'(frame_height);
        if (fw == '0) begin
            w_eff = SW'(1);
        end else if (fw > SW'(MAX_WIDTH)) begin
            w_eff = SW'(MAX_WIDTH);
        end else begin
            w_eff = fw;
        end
        if (fh == '0) begin
            h_eff = SH'(1);
        end else if (fh > SH'(MAX_HEIGHT)) begin
            h_eff = SH'(MAX_HEIGHT);
        end else begin
            h_eff = fh;
        end
        col_eff  = s_data.frame_start ? '0 : col_reg;
        row_end  = (SW'(col_eff) + SW'(1)) >= w_eff;
        last_row = (SH'(row_reg) + SH'(1)) >= h_eff;
        restart  = s_data.frame_start && (row_reg != '0);
    end

    assign row = row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.clear_pos) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.accept) begin
            if (row_end) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + RW'(1);
            end else begin
                col_reg <= col_eff + CW'(1);
            end
        end
    end

    always_comb begin
        mx = s_data.pix_red;
        if (s_data.pix_green > mx) begin
            mx = s_data.pix_green;
        end
        if (s_data.pix_blue > mx) begin
            mx = s_data.pix_blue;
        end
        if ((s_data.pix_red | s_data.pix_green | s_data.pix_blue) == 8'd0) begin
            alpha = 8'd0;
        end else if (mx < ALPHA_FLOOR) begin
            alpha = ALPHA_FLOOR;
        end else begin
            alpha = mx;
        end
        alpha_inv = ALPHA_FULL - alpha;
        alpha_mul = plate_enable ? ALPHA_FULL : alpha;
        plate_r   = plate_color[7:0];
        plate_g   = plate_color[15:8];
        plate_b   = plate_color[23:16];
    end

    // stage 1: products
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            st1_r_reg     <= s_data.pix_red;
            st1_g_reg     <= s_data.pix_green;
            st1_b_reg     <= s_data.pix_blue;
            st1_mr_reg    <= 16'(s_data.pix_red) * 16'(alpha);
            st1_mg_reg    <= 16'(s_data.pix_green) * 16'(alpha);
            st1_mb_reg    <= 16'(s_data.pix_blue) * 16'(alpha);
            st1_pr_reg    <= 16'(plate_r) * 16'(alpha_inv);
            st1_pg_reg    <= 16'(plate_g) * 16'(alpha_inv);
            st1_pb_reg    <= 16'(plate_b) * 16'(alpha_inv);
            st1_am_reg    <= AW'(alpha_mul) * AW'(fade);
            st1_end_reg   <= row_end && last_row;
            st1_plate_reg <= plate_enable;
        end
    end

    // stage 2: rounding and blend select
    always_comb begin
        alpha_rnd = (AW + 1)'(st1_am_reg) + HALF;
        out_next.out_alpha = alpha_rnd[F+7:F];
        out_next.frame_end = st1_end_reg;
        if (st1_plate_reg) begin
            out_next.out_red   = div255(st1_mr_reg, st1_pr_reg);
            out_next.out_green = div255(st1_mg_reg, st1_pg_reg);
            out_next.out_blue  = div255(st1_mb_reg, st1_pb_reg);
        end else begin
            out_next.out_red   = st1_r_reg;
            out_next.out_green = st1_g_reg;
            out_next.out_blue  = st1_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

>>> rtl/ofc_ctrl.sv
// Controller: fade recompute sequencing and the two-stage pixel pipeline
// handshake. Depends on ofc_pkg.
module ofc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  logic               cfg_we,
    input  ofc_pkg::ofc_sts_t  sts,
    output ofc_pkg::ofc_cmd_t  cmd
);
    import ofc_pkg::*;

    ofc_state_t state_reg, state_next;
    logic       st1_valid_reg, st1_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic       adv_out, adv1, do_restart;

    always_comb begin
        adv_out    = !out_valid_reg || m_ready;
        adv1       = !st1_valid_reg || adv_out;
        do_restart = (state_reg == ST_RUN) && s_valid && sts.restart;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        if (cfg_we) begin
            state_next = ST_SETUP;
        end else begin
            unique case (state_reg)
                ST_SETUP: state_next = sts.fade_trivial ? ST_RUN : ST_DIV;
                ST_DIV:   state_next = sts.div_last ? ST_RUN : ST_DIV;
                ST_RUN: begin
                    if (do_restart || (cmd.accept && sts.row_end)) begin
                        state_next = ST_SETUP;
                    end
                end
                default:  state_next = ST_SETUP;
            endcase
        end
    end

    // outputs
    always_comb begin
        s_ready       = (state_reg == ST_RUN) && adv1 && !sts.restart;
        cmd.accept    = s_valid && s_ready;
        cmd.clear_pos = do_restart;
        cmd.out_load  = st1_valid_reg && adv_out;
        cmd.div_load  = (state_reg == ST_SETUP);
        cmd.div_step  = (state_reg == ST_DIV);
        m_valid       = out_valid_reg;

        st1_valid_next = cmd.accept || (st1_valid_reg && !adv_out);
        out_valid_next = cmd.out_load || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SETUP;
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            st1_valid_reg <= st1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_row_end_refade: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && sts.row_end) |=> state_reg == ST_SETUP)
        else $error("row change without fade recompute");

    a_no_st1_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && !adv_out) |-> !cmd.accept)
        else $error("stage 1 overwritten while held");

    a_restart_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        do_restart |-> !cmd.accept)
        else $error("frame start taken before row zero fade");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV || state_reg == ST_SETUP) |-> !cmd.accept)
        else $error("word accepted while fade recompute runs");

endmodule

>>> rtl/overlay_alpha_fade_composite.sv
// Top level of the overlay alpha/fade compositor: config registers and
// instances of ofc_ctrl, ofc_fade and ofc_pixel. Depends on ofc_pkg.
//
//   channel  | ports                    | word
//   ---------+--------------------------+-----------------------------------
//   input    | s_valid s_ready s_data   | frame_start, pix_red/green/blue
//   result   | m_valid m_ready m_data   | out_red/green/blue/alpha, frame_end
//   config   | cfg_we cfg_index cfg_data| one register per write, no wait
//
// One pixel per cycle inside a row unless the result side stalls; an accepted
// word passes the product register, then the output register. Each row change,
// frame start on a nonzero row and config write runs a fade recompute in the
// shared divider: a setup state, then the divide steps in ST_DIV (setup only
// when the row lies outside or fully inside the bands). After reset the row-zero
// fade is computed before the first word is taken. A stalled result holds in the
// output register while one more word waits in the product stage.
module overlay_alpha_fade_composite #(
    parameter int MAX_WIDTH          = 4096,
    parameter int MAX_HEIGHT         = 4096,
    parameter int FADE_FRACTION_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ofc_pkg::ofc_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ofc_pkg::ofc_out_t                 m_data,
    input  logic                              cfg_we,
    input  logic [ofc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ofc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ofc_pkg::*;

    localparam int F  = FADE_FRACTION_BITS;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [12:0] frame_width_reg, frame_height_reg;
    logic [13:0] top_zero_reg, top_opaque_reg, bottom_opaque_reg, bottom_zero_reg;
    logic        plate_enable_reg;
    logic [23:0] plate_color_reg;

    ofc_cmd_t      cmd;
    ofc_sts_t      sts;
    logic [F:0]    fade;
    logic [RW-1:0] row;
    logic          row_end, restart, fade_trivial, div_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= 13'd1920;
            frame_height_reg  <= 13'd1080;
            top_zero_reg      <= 14'd0;
            top_opaque_reg    <= 14'd0;
            bottom_opaque_reg <= 14'd8192;
            bottom_zero_reg   <= 14'd8192;
            plate_enable_reg  <= 1'b0;
            plate_color_reg   <= 24'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[12:0];
                CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[12:0];
                CFG_TOP_ZERO:      top_zero_reg      <= cfg_data[13:0];
                CFG_TOP_OPAQUE:    top_opaque_reg    <= cfg_data[13:0];
                CFG_BOTTOM_OPAQUE: bottom_opaque_reg <= cfg_data[13:0];
                CFG_BOTTOM_ZERO:   bottom_zero_reg   <= cfg_data[13:0];
                CFG_PLATE_ENABLE:  plate_enable_reg  <= cfg_data[0];
                CFG_PLATE_COLOR:   plate_color_reg   <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        sts.row_end      = row_end;
        sts.restart      = restart;
        sts.fade_trivial = fade_trivial;
        sts.div_last     = div_last;
    end

    ofc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cfg_we  (cfg_we),
        .sts     (sts),
        .cmd     (cmd)
    );

    ofc_fade #(
        .F  (F),
        .RW (RW)
    ) u_fade (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .row           (row),
        .top_zero      (top_zero_reg),
        .top_opaque    (top_opaque_reg),
        .bottom_opaque (bottom_opaque_reg),
        .bottom_zero   (bottom_zero_reg),
        .fade          (fade),
        .trivial       (fade_trivial),
        .div_last      (div_last)
    );

    ofc_pixel #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .F          (F),
        .CW         (CW),
        .RW         (RW)
    ) u_pixel (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_data       (s_data),
        .fade         (fade),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .plate_enable (plate_enable_reg),
        .plate_color  (plate_color_reg),
        .m_data       (m_data),
        .row          (row),
        .row_end      (row_end),
        .restart      (restart)
    );

endmodule

>>> sim/tb_overlay_alpha_fade_composite.sv
// Self-checking bench for overlay_alpha_fade_composite: random and directed pixel
// words, register setups between phases, and an in-order model of the result stream.
// Depends on ofc_pkg and the RTL under rtl/.
module tb_overlay_alpha_fade_composite;
    timeunit 1ns;
    timeprecision 1ps;
    import ofc_pkg::*;

    localparam int unsigned FADE_BITS       = 8;
    localparam int unsigned FADE_ONE        = 1 << FADE_BITS;
    localparam int unsigned FADE_HALF       = 1 << (FADE_BITS - 1);
    localparam int unsigned MAX_DIM         = 4096;
    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          SETTLE_CYCLES   = 32;
    localparam int          RANDOM_PHASES   = 12;
    localparam int          WORDS_PER_PHASE = 119;

    // {frame_start, red, green, blue}, reset register values
    localparam bit [24:0] OPENING_WORDS [12] = '{
        25'h1000000, 25'h0FFFFFF, 25'h0010000, 25'h0000100,
        25'h0000001, 25'h0950000, 25'h0009600, 25'h0000097,
        25'h08040C8, 25'h0AAAAAA, 25'h1FF0000, 25'h0000000
    };
    // 3x5 frame with both fade bands and the plate on
    localparam bit [24:0] BANDED_WORDS [12] = '{
        25'h1FFFFFF, 25'h0000000, 25'h0102030, 25'h0FF0000,
        25'h000FF00, 25'h00000FF, 25'h0969696, 25'h0959595,
        25'h0123456, 25'h0FEDCBA, 25'h0808080, 25'h1000001
    };

    class pixel_composite_sb;
        int unsigned width_reg, height_reg;
        int unsigned top_zero, top_opaque, bottom_opaque, bottom_zero;
        bit          plate_on;
        int unsigned plate_bgr;
        int unsigned col, row;
        ofc_out_t    expected_pixels[$];
        int          errors;

        function new();
            width_reg     = 1920;
            height_reg    = 1080;
            top_zero      = 0;
            top_opaque    = 0;
            bottom_opaque = 8192;
            bottom_zero   = 8192;
            plate_on      = 1'b0;
            plate_bgr     = 0;
            col           = 0;
            row           = 0;
            errors        = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_FRAME_WIDTH:   width_reg     = value[12:0];
                CFG_FRAME_HEIGHT:  height_reg    = value[12:0];
                CFG_TOP_ZERO:      top_zero      = value[13:0];
                CFG_TOP_OPAQUE:    top_opaque    = value[13:0];
                CFG_BOTTOM_OPAQUE: bottom_opaque = value[13:0];
                CFG_BOTTOM_ZERO:   bottom_zero   = value[13:0];
                CFG_PLATE_ENABLE:  plate_on      = value[0];
                CFG_PLATE_COLOR:   plate_bgr     = value[23:0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(int unsigned v);
            if (v < 1) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return v;
        endfunction

        // edges are in half-pixel units, so row r sits at 2r
        function int unsigned fade_for_row(int unsigned r);
            int unsigned p, num, den, q;
            p = 2 * r;
            if (p < top_opaque) begin
                if (p <= top_zero) return 0;
                num = p - top_zero;
                den = top_opaque - top_zero;
            end else if (p > bottom_opaque) begin
                if (p >= bottom_zero) return 0;
                num = bottom_zero - p;
                den = bottom_zero - bottom_opaque;
            end else begin
                return FADE_ONE;
            end
            q = ((num << FADE_BITS) + den / 2) / den;
            return (q > FADE_ONE) ? FADE_ONE : q;
        endfunction

        function void note_pixel(ofc_in_t px);
            int unsigned w, h, r, g, b, a, fade, inv;
            bit          row_end, last_row;
            ofc_out_t    want;
            w = clamp_dim(width_reg);
            h = clamp_dim(height_reg);
            r = px.pix_red;
            g = px.pix_green;
            b = px.pix_blue;
            if (px.frame_start) begin
                col = 0;
                row = 0;
            end
            fade = fade_for_row(row);
            if ((r | g | b) == 0) begin
                a = 0;
            end else begin
                a = r;
                if (g > a) a = g;
                if (b > a) a = b;
                if (a < ALPHA_FLOOR) a = ALPHA_FLOOR;
            end
            if (plate_on) begin
                inv = ALPHA_FULL - a;
                want.out_red   = 8'((r * a + (plate_bgr & 8'hff) * inv + 127) / ALPHA_FULL);
                want.out_green = 8'((g * a + ((plate_bgr >> 8) & 8'hff) * inv + 127)
                                    / ALPHA_FULL);
                want.out_blue  = 8'((b * a + ((plate_bgr >> 16) & 8'hff) * inv + 127)
                                    / ALPHA_FULL);
                want.out_alpha = 8'((ALPHA_FULL * fade + FADE_HALF) >> FADE_BITS);
            end else begin
                want.out_red   = 8'(r);
                want.out_green = 8'(g);
                want.out_blue  = 8'(b);
                want.out_alpha = 8'((a * fade + FADE_HALF) >> FADE_BITS);
            end
            // counters left past a shrunk frame still end the row / frame
            row_end        = (col + 1 >= w);
            last_row       = (row + 1 >= h);
            want.frame_end = row_end && last_row;
            expected_pixels = {expected_pixels, want};
            if (row_end) begin
                col = 0;
                row = last_row ? 0 : ((row + 1) & 12'hfff);
            end else begin
                col = (col + 1) & 12'hfff;
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_pixel(ofc_out_t got);
            ofc_out_t want;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing expected", got));
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("out_red",   got.out_red,   want.out_red);
            compare_field("out_green", got.out_green, want.out_green);
            compare_field("out_blue",  got.out_blue,  want.out_blue);
            compare_field("out_alpha", got.out_alpha, want.out_alpha);
            compare_field("frame_end", 8'(got.frame_end), 8'(want.frame_end));
        endtask

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    ofc_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    ofc_out_t              m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    pixel_composite_sb book = new();
    int  tx_idle_pct = 18;
    int  rx_idle_pct = 78;
    int  hold_left   = 0;
    bit  hold_kick   = 1'b0;
    int  cycle_count = 0;

    overlay_alpha_fade_composite u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) book.note_pixel(s_data);
            if (m_valid && m_ready) book.check_pixel(m_data);
        end
    end

    // result side: random back-pressure, or one long hold-off when kicked
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else if (hold_kick) begin
            hold_kick = 1'b0;
            hold_left = HOLD_CYCLES;
            m_ready   = 1'b0;
        end else begin
            m_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_pixel(ofc_in_t px);
        @(negedge aclk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = px;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value[CFG_DATA_W-1:0];
        book.set_register(idx, value[CFG_DATA_W-1:0]);
    endtask

    task automatic apply_setup(int unsigned w, int unsigned h, int unsigned tz,
                               int unsigned tp, int unsigned bp, int unsigned bz,
                               int unsigned pe, int unsigned pc);
        write_register(CFG_FRAME_WIDTH, w);
        write_register(CFG_FRAME_HEIGHT, h);
        write_register(CFG_TOP_ZERO, tz);
        write_register(CFG_TOP_OPAQUE, tp);
        write_register(CFG_BOTTOM_OPAQUE, bp);
        write_register(CFG_BOTTOM_ZERO, bz);
        write_register(CFG_PLATE_ENABLE, pe);
        write_register(CFG_PLATE_COLOR, pc);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic random_setup(int ph);
        int unsigned w, h, tz, tp, bp, bz;
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 20);
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0:       w = 0;
                1:       w = 4096;
                2:       w = 4097;
                default: w = 13'h1fff;
            endcase
        end
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0:       h = 0;
                1:       h = 4096;
                2:       h = 4097;
                default: h = 13'h1fff;
            endcase
        end
        if ($urandom_range(3) == 0) begin
            // unordered edges: inverted and empty bands
            tz = $urandom_range(0, 2 * h + 4);
            tp = $urandom_range(0, 2 * h + 4);
            bp = $urandom_range(0, 2 * h + 4);
            bz = $urandom_range(0, 2 * h + 4);
        end else begin
            tz = $urandom_range(0, 4);
            tp = tz + $urandom_range(0, 8);
            bp = tp + $urandom_range(0, 2 * h);
            bz = bp + $urandom_range(0, 8);
        end
        if (ph == 2)
            apply_setup(13'h1fff, 13'h1fff, 14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff,
                        1, 24'hffffff);
        else if (ph == 6)
            apply_setup(0, 0, 0, 0, 0, 0, 0, 0);
        else
            apply_setup(w, h, tz, tp, bp, bz, $urandom_range(1), $urandom_range(24'hffffff));
    endtask

    function automatic ofc_in_t random_pixel(bit phase_head);
        ofc_in_t     px;
        int unsigned lo, hi;
        case ($urandom_range(9))
            0:       begin lo = 0;   hi = 0;   end
            1:       begin lo = 0;   hi = 149; end
            2:       begin lo = 140; hi = 160; end
            default: begin lo = 0;   hi = 255; end
        endcase
        px.frame_start = phase_head ? 1'($urandom_range(1)) : ($urandom_range(47) == 0);
        px.pix_red     = 8'($urandom_range(lo, hi));
        px.pix_green   = 8'($urandom_range(lo, hi));
        px.pix_blue    = 8'($urandom_range(lo, hi));
        return px;
    endfunction

    // let every expected word come out, then give the fade divider time to finish
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid = 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (OPENING_WORDS[i]) send_pixel(ofc_in_t'(OPENING_WORDS[i]));
        drain_pipeline();
        apply_setup(3, 5, 1, 4, 5, 9, 1, 24'h3c80f0);
        foreach (BANDED_WORDS[i]) send_pixel(ofc_in_t'(BANDED_WORDS[i]));

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_pipeline();
            if (ph == RANDOM_PHASES / 3) begin
                tx_idle_pct = 78;
                rx_idle_pct = 18;
            end else if (ph == 2 * RANDOM_PHASES / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            random_setup(ph);
            if (ph == RANDOM_PHASES - 2) hold_kick = 1'b1;
            for (int n = 0; n < WORDS_PER_PHASE; n++) send_pixel(random_pixel(n == 0));
        end

        drain_pipeline();
        if (book.errors == 0 && book.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> sim.f
rtl/ofc_pkg.sv
rtl/ofc_fade.sv
rtl/ofc_pixel.sv
rtl/ofc_ctrl.sv
rtl/overlay_alpha_fade_composite.sv
sim/tb_overlay_alpha_fade_composite.sv
